/* design/lzs_pkg.sv */
// ----------------------------------------------------------------------------
// LZ sequence symbolizer package
// Shared constants, item layouts and symbol coding functions.
// ----------------------------------------------------------------------------
package lzs_pkg;

  localparam int SYM_DEPTH  = 64;
  localparam int SYM_AW     = $clog2(SYM_DEPTH);
  localparam int CNT_W      = 32;
  localparam int OFF_W      = 16;
  localparam int BYTE_DEPTH = 256;
  localparam int BYTE_AW    = $clog2(BYTE_DEPTH);
  localparam int NUM_REP    = 3;
  localparam int LEN_W      = 13;
  localparam int DIRECT_LIMIT = 16;
  localparam int MIN_MATCH  = 4;
  localparam int LEN_BASE   = 12;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int COUNT_OUT_W = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OFF_W-1:0] REP_INIT [NUM_REP] = '{OFF_W'(1), OFF_W'(4), OFF_W'(8)};

  typedef enum logic [1:0] {
    OP_SEQ  = 2'd0,
    OP_LIT  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } lzs_op_e;

  typedef enum logic [1:0] {
    SEL_LL   = 2'd0,
    SEL_ML   = 2'd1,
    SEL_OFF  = 2'd2,
    SEL_BYTE = 2'd3
  } lzs_sel_e;

  typedef struct packed {
    logic [5:0] code;
    logic [3:0] extra;
  } lzs_sym_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    lzs_sym_t            ll;
    logic                present;
    lzs_sym_t            ml;
    lzs_sym_t            off;
    logic                ll_inc;
    logic                ml_inc;
    logic                off_inc;
    logic                byte_inc;
    logic [SYM_AW-1:0]   ll_addr;
    logic [SYM_AW-1:0]   ml_addr;
    logic [SYM_AW-1:0]   off_addr;
    logic [BYTE_AW-1:0]  byte_addr;
    logic                rd_en;
    lzs_sel_e            rd_sel;
  } lzs_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } lzs_qstat_t;

  // Bit width minus one, zero for a zero value.
  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [4:0] b;
    b = '0;
    for (int i = 1; i < 32; i++) begin
      if (v[i]) b = 5'(i);
    end
    return b;
  endfunction

  function automatic lzs_sym_t len_sym(input logic [LEN_W-1:0] v);
    lzs_sym_t   s;
    logic [4:0] b;
    b = top_bit(32'(v));
    if (v < LEN_W'(DIRECT_LIMIT)) begin
      s.code  = 6'(v);
      s.extra = '0;
    end else begin
      s.code  = 6'(b) + 6'(LEN_BASE);
      s.extra = b[3:0];
    end
    return s;
  endfunction

  function automatic lzs_sym_t off_bucket(input logic [OFF_W-1:0] o);
    lzs_sym_t   s;
    logic [4:0] b;
    b = top_bit(32'(o));
    s.code  = 6'(b) + 6'(NUM_REP);
    s.extra = b[3:0];
    return s;
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    if (w > 64'hFFFF_FFFF) return '1;
    return w[COUNT_OUT_W-1:0];
  endfunction

endpackage

/* design/lzs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lzs_front.sv */
// ----------------------------------------------------------------------------
// LZ symbolizer front part
// Accepts items, codes lengths and offsets, and keeps the repeat offsets.
// ----------------------------------------------------------------------------
module lzs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lzs_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic [lzs_pkg::IN_USER_W-1:0] in_user_i,
  input  lzs_pkg::lzs_qstat_t           q_stat_i,
  output logic                          push_o,
  output lzs_pkg::lzs_entry_t           entry_o
);
  import lzs_pkg::*;

  logic                repeat_en_q;
  logic [OFF_W-1:0]    rep_q   [NUM_REP];
  logic [OFF_W-1:0]    rep_d   [NUM_REP];
  logic [OFF_W-1:0]    rep_cur [NUM_REP];
  logic [NUM_REP-1:0]  hit;

  lzs_op_e             op;
  logic                page_start;
  logic [LEN_W-1:0]    lit_len;
  logic [LEN_W-1:0]    mat_len;
  logic [LEN_W-1:0]    ml_val;
  logic [15:0]         match_off;
  logic [OFF_W-1:0]    off_val;
  logic [7:0]          lit_val;
  lzs_sel_e            tsel;
  logic [7:0]          tidx;
  logic                present;
  lzs_sym_t            ll_sym;
  lzs_sym_t            ml_sym;
  lzs_sym_t            off_sym;
  lzs_entry_t          ent;

  assign op         = lzs_op_e'(in_user_i);
  assign page_start = in_data_i[0];
  assign lit_len    = in_data_i[13:1];
  assign mat_len    = in_data_i[26:14];
  assign match_off  = in_data_i[42:27];
  assign lit_val    = in_data_i[50:43];
  assign tsel       = lzs_sel_e'(in_data_i[52:51]);
  assign tidx       = in_data_i[60:53];

  assign off_val = OFF_W'(match_off);
  assign present = (mat_len != '0);
  assign ml_val  = (mat_len < LEN_W'(MIN_MATCH)) ? '0 : mat_len - LEN_W'(MIN_MATCH);
  assign ll_sym  = len_sym(lit_len);
  assign ml_sym  = len_sym(ml_val);

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    for (int k = 0; k < NUM_REP; k++) begin
      rep_cur[k] = page_start ? REP_INIT[k] : rep_q[k];
      hit[k]     = repeat_en_q && (rep_cur[k] == off_val);
    end
  end

  always_comb begin
    if (hit[0]) begin
      off_sym = '{code: 6'd0, extra: 4'd0};
    end else if (hit[1]) begin
      off_sym = '{code: 6'd1, extra: 4'd0};
    end else if (hit[2]) begin
      off_sym = '{code: 6'd2, extra: 4'd0};
    end else begin
      off_sym = off_bucket(off_val);
    end
  end

  // Move-to-front: a hit at slot r shifts slots below r, a miss shifts all.
  always_comb begin
    for (int k = 0; k < NUM_REP; k++) rep_d[k] = rep_q[k];
    if (push_o && op == OP_SEQ) begin
      for (int k = 0; k < NUM_REP; k++) rep_d[k] = rep_cur[k];
      if (present) begin
        rep_d[0] = off_val;
        if (!hit[0]) rep_d[1] = rep_cur[0];
        if (!hit[0] && !hit[1]) rep_d[2] = rep_cur[1];
      end
    end
  end

  always_comb begin
    ent = '0;
    unique case (op)
      OP_SEQ: begin
        ent.ll      = ll_sym;
        ent.ll_inc  = ({1'b0, ll_sym.code} < 7'(SYM_DEPTH));
        ent.ll_addr = ll_sym.code[SYM_AW-1:0];
        if (present) begin
          ent.present  = 1'b1;
          ent.ml       = ml_sym;
          ent.ml_inc   = ({1'b0, ml_sym.code} < 7'(SYM_DEPTH));
          ent.ml_addr  = ml_sym.code[SYM_AW-1:0];
          ent.off      = off_sym;
          ent.off_inc  = ({1'b0, off_sym.code} < 7'(SYM_DEPTH));
          ent.off_addr = off_sym.code[SYM_AW-1:0];
        end
      end
      OP_LIT: begin
        ent.byte_inc  = 1'b1;
        ent.byte_addr = lit_val;
      end
      OP_READ: begin
        ent.rd_sel    = tsel;
        ent.rd_en     = (tsel == SEL_BYTE) || ({1'b0, tidx} < 9'(SYM_DEPTH));
        ent.ll_addr   = tidx[SYM_AW-1:0];
        ent.ml_addr   = tidx[SYM_AW-1:0];
        ent.off_addr  = tidx[SYM_AW-1:0];
        ent.byte_addr = tidx;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_en_q <= 1'b1;
      for (int k = 0; k < NUM_REP; k++) rep_q[k] <= REP_INIT[k];
    end else begin
      if (cfg_we_i) repeat_en_q <= cfg_wdata_i;
      for (int k = 0; k < NUM_REP; k++) rep_q[k] <= rep_d[k];
    end
  end

endmodule

/* design/lzs_queue.sv */
// ----------------------------------------------------------------------------
// LZ symbolizer item queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module lzs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lzs_pkg::lzs_entry_t entry_i,
  input  logic                pop_i,
  output lzs_pkg::lzs_entry_t entry_o,
  output lzs_pkg::lzs_qstat_t stat_o
);
  import lzs_pkg::*;

  lzs_entry_t          ent_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q;
  logic [QUEUE_AW-1:0] rd_ptr_q;
  logic [QUEUE_CW-1:0] cnt_q;

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign entry_o      = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QUEUE_CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QUEUE_CW'(1);
      end
    end
  end

endmodule

/* design/lzs_back.sv */
// ----------------------------------------------------------------------------
// LZ symbolizer back part
// Updates and reads the histograms and holds the result item.
// ----------------------------------------------------------------------------
module lzs_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lzs_pkg::lzs_qstat_t            q_stat_i,
  input  lzs_pkg::lzs_entry_t            entry_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lzs_pkg::OUT_DATA_W-1:0] out_data_o
);
  import lzs_pkg::*;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + CNT_W'(1);
  endfunction

  logic       a_fire;
  logic       b_adv;
  logic       b_valid_q;
  lzs_entry_t b_q;

  // Clearing pass after reset: walks every histogram address writing zero.
  logic               clr_q;
  logic [BYTE_AW-1:0] clr_addr_q;

  logic [CNT_W-1:0] ll_rdata, ml_rdata, off_rdata, by_rdata;
  logic [CNT_W-1:0] ll_cur, ml_cur, off_cur, by_cur;
  logic [CNT_W-1:0] ll_nxt, ml_nxt, off_nxt, by_nxt;
  logic [CNT_W-1:0] sel_cur;
  logic             ll_upd, ml_upd, off_upd, by_upd;
  logic             ll_we, ml_we, off_we, by_we;
  logic [SYM_AW-1:0]  ll_wa, ml_wa, off_wa;
  logic [BYTE_AW-1:0] by_wa;
  logic [CNT_W-1:0]   ll_wd, ml_wd, off_wd, by_wd;

  // Last write of each table, to cover the read issued on the same edge.
  logic                ll_lw_q, ml_lw_q, off_lw_q, by_lw_q;
  logic [SYM_AW-1:0]   ll_lwa_q, ml_lwa_q, off_lwa_q;
  logic [BYTE_AW-1:0]  by_lwa_q;
  logic [CNT_W-1:0]    ll_lwd_q, ml_lwd_q, off_lwd_q, by_lwd_q;

  logic                     out_valid_q;
  logic [OUT_DATA_W-1:0]    out_data_q;
  logic [COUNT_OUT_W-1:0]   count_val;

  assign b_adv  = b_valid_q && (!out_valid_q || out_ready_i);
  assign a_fire = q_stat_i.valid && !clr_q && (!b_valid_q || b_adv);
  assign pop_o  = a_fire;

  assign ll_upd  = b_adv && b_q.ll_inc;
  assign ml_upd  = b_adv && b_q.ml_inc;
  assign off_upd = b_adv && b_q.off_inc;
  assign by_upd  = b_adv && b_q.byte_inc;

  assign ll_we  = clr_q || ll_upd;
  assign ml_we  = clr_q || ml_upd;
  assign off_we = clr_q || off_upd;
  assign by_we  = clr_q || by_upd;

  assign ll_wa  = clr_q ? clr_addr_q[SYM_AW-1:0] : b_q.ll_addr;
  assign ml_wa  = clr_q ? clr_addr_q[SYM_AW-1:0] : b_q.ml_addr;
  assign off_wa = clr_q ? clr_addr_q[SYM_AW-1:0] : b_q.off_addr;
  assign by_wa  = clr_q ? clr_addr_q : b_q.byte_addr;

  assign ll_wd  = clr_q ? '0 : ll_nxt;
  assign ml_wd  = clr_q ? '0 : ml_nxt;
  assign off_wd = clr_q ? '0 : off_nxt;
  assign by_wd  = clr_q ? '0 : by_nxt;

  lzs_ram #(.WIDTH(CNT_W), .DEPTH(SYM_DEPTH)) u_ll_ram (
    .clk_i, .we_i(ll_we), .waddr_i(ll_wa), .wdata_i(ll_wd),
    .re_i(a_fire), .raddr_i(entry_i.ll_addr), .rdata_o(ll_rdata)
  );

  lzs_ram #(.WIDTH(CNT_W), .DEPTH(SYM_DEPTH)) u_ml_ram (
    .clk_i, .we_i(ml_we), .waddr_i(ml_wa), .wdata_i(ml_wd),
    .re_i(a_fire), .raddr_i(entry_i.ml_addr), .rdata_o(ml_rdata)
  );

  lzs_ram #(.WIDTH(CNT_W), .DEPTH(SYM_DEPTH)) u_off_ram (
    .clk_i, .we_i(off_we), .waddr_i(off_wa), .wdata_i(off_wd),
    .re_i(a_fire), .raddr_i(entry_i.off_addr), .rdata_o(off_rdata)
  );

  lzs_ram #(.WIDTH(CNT_W), .DEPTH(BYTE_DEPTH)) u_byte_ram (
    .clk_i, .we_i(by_we), .waddr_i(by_wa), .wdata_i(by_wd),
    .re_i(a_fire), .raddr_i(entry_i.byte_addr), .rdata_o(by_rdata)
  );

  assign ll_cur  = (ll_lw_q && ll_lwa_q == b_q.ll_addr) ? ll_lwd_q : ll_rdata;
  assign ml_cur  = (ml_lw_q && ml_lwa_q == b_q.ml_addr) ? ml_lwd_q : ml_rdata;
  assign off_cur = (off_lw_q && off_lwa_q == b_q.off_addr) ? off_lwd_q : off_rdata;
  assign by_cur  = (by_lw_q && by_lwa_q == b_q.byte_addr) ? by_lwd_q : by_rdata;

  assign ll_nxt  = sat_inc(ll_cur);
  assign ml_nxt  = sat_inc(ml_cur);
  assign off_nxt = sat_inc(off_cur);
  assign by_nxt  = sat_inc(by_cur);

  always_comb begin
    case (b_q.rd_sel)
      SEL_LL:   sel_cur = ll_cur;
      SEL_ML:   sel_cur = ml_cur;
      SEL_OFF:  sel_cur = off_cur;
      default:  sel_cur = by_cur;
    endcase
  end

  assign count_val = b_q.rd_en ? sat_count(sel_cur) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      ll_lw_q     <= 1'b0;
      ml_lw_q     <= 1'b0;
      off_lw_q    <= 1'b0;
      by_lw_q     <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + BYTE_AW'(1);
        if (clr_addr_q == '1) clr_q <= 1'b0;
      end
      if (a_fire) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ll_upd)  ll_lw_q  <= 1'b1;
      if (ml_upd)  ml_lw_q  <= 1'b1;
      if (off_upd) off_lw_q <= 1'b1;
      if (by_upd)  by_lw_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) b_q <= entry_i;
    if (ll_upd) begin
      ll_lwa_q <= b_q.ll_addr;
      ll_lwd_q <= ll_nxt;
    end
    if (ml_upd) begin
      ml_lwa_q <= b_q.ml_addr;
      ml_lwd_q <= ml_nxt;
    end
    if (off_upd) begin
      off_lwa_q <= b_q.off_addr;
      off_lwd_q <= off_nxt;
    end
    if (by_upd) begin
      by_lwa_q <= b_q.byte_addr;
      by_lwd_q <= by_nxt;
    end
    if (b_adv) begin
      out_data_q <= {1'b0, count_val, b_q.off.extra, b_q.off.code, b_q.ml.extra,
                     b_q.ml.code, b_q.present, b_q.ll.extra, b_q.ll.code};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* design/lz_sequence_symbolizer.sv */
// ----------------------------------------------------------------------------
// LZ sequence symbolizer
// Maps LZ sequences to length and offset symbols and keeps histograms.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                 Contents
//   s_axis   in         s_axis_tvalid/tready      sequence, literal or read item
//   m_axis   out        m_axis_tvalid/tready      symbols and histogram count
//   cfg      in         cfg_we_i                  repeat_enable
//
// One item is accepted per cycle in steady flow; its result passes through the
// queue and then the histogram RAM read stage that loads the output register.
// Histogram updates are a read-modify-write with forwarding of the last write.
// After reset a clearing pass over every histogram address zeroes the histograms
// while items wait in the queue. A stalled output fills the two-entry queue
// before s_axis_tready drops.
// ----------------------------------------------------------------------------
module lz_sequence_symbolizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] page_start, [13:1] literal_length, [26:14] match_length,
  // [42:27] match_offset, [50:43] literal_value, [52:51] table_select,
  // [60:53] table_index, [63:61] zero
  input  logic [lzs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [lzs_pkg::IN_USER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] ll_code, [9:6] ll_extra_bits, [10] match_present, [16:11] ml_code,
  // [20:17] ml_extra_bits, [26:21] off_code, [30:27] off_extra_bits,
  // [62:31] count_value, [63] zero
  output logic [lzs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import lzs_pkg::*;

  logic       q_push;
  logic       q_pop;
  lzs_entry_t q_in;
  lzs_entry_t q_out;
  lzs_qstat_t q_stat;

  lzs_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  lzs_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .stat_o  (q_stat)
  );

  lzs_back u_back (
    .clk_i,
    .rst_ni,
    .q_stat_i    (q_stat),
    .entry_i     (q_out),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // A sequence without a match carries no match or offset symbol.
  a_no_match_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[10]) |-> (m_axis_tdata[30:11] == '0))
    else $error("match fields set without a match");

  // A nonzero count only comes from a read, which carries no symbols.
  a_count_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[62:31] != '0) |-> (m_axis_tdata[30:0] == '0))
    else $error("count returned together with symbols");

  // An item pushed into the queue is visible to the back part next cycle.
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |=> q_stat.valid)
    else $error("queue lost an item");

endmodule
